>>> hw/rtl/pcm_format_rate_convert_macros.svh
// assertion macros for the pcm format and rate converter
`ifndef PCM_FORMAT_RATE_CONVERT_MACROS_SVH
`define PCM_FORMAT_RATE_CONVERT_MACROS_SVH

// property checked on every rising edge of clk_i outside reset
`define PFRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pfrc assertion failed");

// condition that must never hold outside reset
`define PFRC_ASSERT_NEVER(lbl, cond) \
  `PFRC_ASSERT(lbl, !(cond))

`endif

>>> hw/rtl/pfrc_pkg.sv
// types and constants of the pcm format and rate converter
`default_nettype none

package pfrc_pkg;

  localparam int unsigned FrameCountBitsDef = 24;
  localparam int unsigned CodeW             = 16;
  localparam int unsigned RateW             = 18;
  localparam int unsigned IndexW            = 42;
  localparam int unsigned CfgIdxW           = 3;

  localparam logic [RateW-1:0] RateReset = RateW'(44100);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_SIXTEEN_BIT = 3'd0,
    CFG_DST_SIXTEEN_BIT = 3'd1,
    CFG_SRC_STEREO      = 3'd2,
    CFG_DST_STEREO      = 3'd3,
    CFG_SRC_RATE        = 3'd4,
    CFG_DST_RATE        = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CodeW-1:0] left_code;
    logic [CodeW-1:0] right_code;
    logic             restart;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0] dst_index;
    logic [CodeW-1:0]  left_out;
    logic [CodeW-1:0]  right_out;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] reg_idx;
    logic [RateW-1:0]   wdata;
  } cfg_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/pfrc_stream_if.sv
// valid/ready channel carrying one payload per transfer
`default_nettype none

interface pfrc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pcm_format_rate_convert.sv
// PCM format and rate converter: one source frame in, one converted frame with its
// destination index out. A frame is taken only while the divider is free. The transfer
// registers counter * dst_rate, then a restoring divider produces one quotient bit a
// cycle until every bit of the product has been divided. The done state then moves the
// result into the output register once that register is free, and the idle state after
// it can take the next frame. The output register lets the next frame start while a
// result still waits to be taken. Sample depth and channel conversion is done at the
// input transfer. A src_rate of zero divides by one; configuration is to be written
// while idle, which the block itself does not enforce.
`default_nettype none

`include "pcm_format_rate_convert_macros.svh"

module pcm_format_rate_convert
  import pfrc_pkg::*;
#(
  parameter int unsigned FRAME_COUNT_BITS = FrameCountBitsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pfrc_stream_if.sink   cfg_i,
  pfrc_stream_if.sink   in_i,
  pfrc_stream_if.source out_o
);

  localparam int unsigned ProdW = FRAME_COUNT_BITS + RateW;
  localparam int unsigned BitW  = $clog2(ProdW);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  function automatic logic [CodeW-1:0] conv_sample(logic [CodeW-1:0] code, logic s16,
                                                   logic d16);
    logic [7:0]       q8;
    logic [CodeW-1:0] res;
    q8 = code[15:8];
    if (code[15] && (code[7:0] != 8'h00)) begin
      q8 = q8 + 8'd1;
    end
    case ({s16, d16})
      2'b11:   res = code;
      2'b00:   res = {8'h00, code[7:0]};
      2'b01:   res = {~code[7], code[6:0], 8'h00};
      default: res = {8'h00, ~q8[7], q8[6:0]};
    endcase
    return res;
  endfunction

  // configuration
  logic             src16_q, dst16_q, src_st_q, dst_st_q;
  logic [RateW-1:0] src_rate_q, dst_rate_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src16_q    <= 1'b1;
      dst16_q    <= 1'b1;
      src_st_q   <= 1'b0;
      dst_st_q   <= 1'b0;
      src_rate_q <= RateReset;
      dst_rate_q <= RateReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_idx)
        CFG_SRC_SIXTEEN_BIT: src16_q    <= cfg_i.data.wdata[0];
        CFG_DST_SIXTEEN_BIT: dst16_q    <= cfg_i.data.wdata[0];
        CFG_SRC_STEREO:      src_st_q   <= cfg_i.data.wdata[0];
        CFG_DST_STEREO:      dst_st_q   <= cfg_i.data.wdata[0];
        CFG_SRC_RATE:        src_rate_q <= cfg_i.data.wdata;
        CFG_DST_RATE:        dst_rate_q <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // control
  state_e                  state_q, state_d;
  logic [FRAME_COUNT_BITS-1:0] cnt_q, cnt_d, count;
  logic [BitW-1:0]         bit_q, bit_d;
  logic                    out_valid_q, out_valid_d;
  logic                    in_fire, out_load, div_last;

  // datapath
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [RateW-1:0]  rem_q, rem_d, div_q;
  logic [RateW:0]    rem_sh;
  logic [RateW+1:0]  diff;
  logic [CodeW-1:0]  left_q, right_q, left_c, right_c;
  out_item_t         out_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign div_last   = (bit_q == BitW'(ProdW - 1));
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign count = in_i.data.restart ? '0 : cnt_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q;
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DIV;
          cnt_d   = count + FRAME_COUNT_BITS'(1);
          bit_d   = '0;
        end
      end
      ST_DIV: begin
        bit_d = bit_q + BitW'(1);
        if (div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // restoring divider, one quotient bit shifted into the product register a cycle
  assign rem_sh = {rem_q, prod_q[ProdW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_q};

  always_comb begin
    prod_d = {prod_q[ProdW-2:0], ~diff[RateW+1]};
    rem_d  = diff[RateW+1] ? rem_sh[RateW-1:0] : diff[RateW-1:0];
  end

  assign left_c  = conv_sample(in_i.data.left_code, src16_q, dst16_q);
  assign right_c = !dst_st_q ? '0 :
                   src_st_q  ? conv_sample(in_i.data.right_code, src16_q, dst16_q) : left_c;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prod_q  <= ProdW'(count) * ProdW'(dst_rate_q);
      rem_q   <= '0;
      div_q   <= (src_rate_q == '0) ? RateW'(1) : src_rate_q;
      left_q  <= left_c;
      right_q <= right_c;
    end else if (state_q == ST_DIV) begin
      prod_q <= prod_d;
      rem_q  <= rem_d;
    end
    if (out_load) begin
      out_q.dst_index <= IndexW'(prod_q);
      out_q.left_out  <= left_q;
      out_q.right_out <= right_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `PFRC_ASSERT(a_fire_starts_div, in_fire |=> (state_q == ST_DIV) && (bit_q == '0))
  `PFRC_ASSERT(a_rem_below_div, (state_q == ST_DIV) |-> (rem_q < div_q))
  `PFRC_ASSERT(a_done_loads_out,
               ((state_q == ST_DONE) && !out_valid_q) |=> out_valid_q && (state_q == ST_IDLE))
  `PFRC_ASSERT_NEVER(a_bit_overrun, (state_q == ST_DIV) && (bit_q > BitW'(ProdW - 1)))

endmodule

`default_nettype wire

>>> bench/tb_pcm_format_rate_convert.sv
// self-checking testbench for the pcm format and rate converter
`timescale 1ns / 100ps

module tb_pcm_format_rate_convert
  import pfrc_pkg::*;
();

  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 3'd7;
  localparam int unsigned LongHold = 400;
  localparam int unsigned PhaseFrames = 120;
  localparam int unsigned RandomPhases = 14;
  localparam int unsigned EndWait = 60;

  class frame_scoreboard;
    bit                          src16;
    bit                          dst16;
    bit                          src_st;
    bit                          dst_st;
    bit [RateW-1:0]              src_rate;
    bit [RateW-1:0]              dst_rate;
    bit [FrameCountBitsDef-1:0]  frame_count;
    out_item_t                   expected_q[$];
    int                          errors;
    int                          frames_noted;
    int                          results_seen;

    function void reset_state();
      src16 = 1'b1;
      dst16 = 1'b1;
      src_st = 1'b0;
      dst_st = 1'b0;
      src_rate = RateReset;
      dst_rate = RateReset;
      frame_count = '0;
    endfunction

    function void write_reg(cfg_item_t w);
      case (w.reg_idx)
        CFG_SRC_SIXTEEN_BIT: src16 = w.wdata[0];
        CFG_DST_SIXTEEN_BIT: dst16 = w.wdata[0];
        CFG_SRC_STEREO:      src_st = w.wdata[0];
        CFG_DST_STEREO:      dst_st = w.wdata[0];
        CFG_SRC_RATE:        src_rate = w.wdata;
        CFG_DST_RATE:        dst_rate = w.wdata;
        default: ;
      endcase
    endfunction

    function bit [CodeW-1:0] convert_code(bit [CodeW-1:0] code);
      int level;
      if (src16) level = int'($signed(code));
      else level = int'(code[7:0]) - 128;
      if (!src16 && dst16) begin
        level = level * 256;
      end else if (src16 && !dst16) begin
        level = level / 256;
        if (level > 127) level = 127;
        if (level < -128) level = -128;
      end
      if (dst16) return level[15:0];
      return {8'h00, 8'(level + 128)};
    endfunction

    function void note_input(in_item_t f);
      out_item_t         want;
      longint unsigned   product;
      longint unsigned   divisor;
      if (f.restart) frame_count = '0;
      divisor = (src_rate == 0) ? 64'd1 : 64'(src_rate);
      product = 64'(frame_count) * 64'(dst_rate);
      want.dst_index = IndexW'(product / divisor);
      want.left_out = convert_code(f.left_code);
      if (!dst_st) want.right_out = '0;
      else if (src_st) want.right_out = convert_code(f.right_code);
      else want.right_out = want.left_out;
      expected_q.push_back(want);
      frame_count = frame_count + 1'b1;
      frames_noted++;
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      errors++;
      if (errors <= 40)
        $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
                 what, results_seen, got, want);
    endtask

    task check_result(out_item_t r);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("dst_index with no frame pending", r.dst_index, 0);
        return;
      end
      want = expected_q.pop_front();
      if (r.dst_index !== want.dst_index) report("dst_index", r.dst_index, want.dst_index);
      if (r.left_out !== want.left_out) report("left_out", r.left_out, want.left_out);
      if (r.right_out !== want.right_out) report("right_out", r.right_out, want.right_out);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  pfrc_stream_if #(.payload_t(cfg_item_t)) cfg_if ();
  pfrc_stream_if #(.payload_t(in_item_t))  in_if ();
  pfrc_stream_if #(.payload_t(out_item_t)) out_if ();

  pcm_format_rate_convert DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  frame_scoreboard sb;
  bit          no_idle;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned stall_left;
  int unsigned stall_draw;
  int          frames_sent;
  int          settings_done;

  always #1 clk_i = ~clk_i;

  // receiver side: random stalls, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req) begin
      out_if.ready <= 1'b0;
      stall_left <= LongHold;
      hold_seen <= hold_req;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (no_idle) begin
      out_if.ready <= 1'b1;
    end else begin
      stall_draw = $urandom_range(0, 99);
      if (stall_draw < 65) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        stall_left <= (stall_draw < 95) ? $urandom_range(0, 3) : $urandom_range(15, 60);
      end
    end
  end

  // transfer monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if (in_if.valid && in_if.ready) sb.note_input(in_if.data);
    end
  end

  function automatic int sender_gap(bit quiet);
    int unsigned draw;
    if (quiet) return 0;
    draw = $urandom_range(0, 99);
    if (draw < 60) return 0;
    if (draw < 90) return $urandom_range(1, 3);
    if (draw < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic bit [CodeW-1:0] pick_code();
    if ($urandom_range(0, 4) != 0) return 16'($urandom);
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      4: return 16'h0080;
      5: return 16'h007F;
      6: return 16'h00FF;
      default: return 16'hFF00;
    endcase
  endfunction

  function automatic bit [RateW-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return 18'd1;
      1: return 18'd192000;
      2: return 18'h3FFFF;
      3: return 18'd0;
      4: return 18'd44100;
      5: return 18'd48000;
      6: return 18'd8000;
      7: return 18'($urandom_range(1, 1000));
      default: return 18'($urandom_range(1, 262143));
    endcase
  endfunction

  function automatic in_item_t make_frame(bit [CodeW-1:0] l, bit [CodeW-1:0] r, bit rs);
    in_item_t f;
    f.left_code = l;
    f.right_code = r;
    f.restart = rs;
    return f;
  endfunction

  function automatic in_item_t random_frame(bit first);
    bit rs;
    rs = first ? 1'($urandom) : ($urandom_range(0, 39) == 0);
    return make_frame(pick_code(), pick_code(), rs);
  endfunction

  task automatic send_frame(in_item_t f, bit quiet);
    int gap;
    gap = sender_gap(quiet);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= f;
    do @(posedge clk_i); while (!in_if.ready);
    frames_sent++;
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [RateW-1:0] value);
    cfg_item_t w;
    w.reg_idx = idx;
    w.wdata = value;
    cfg_if.valid <= 1'b1;
    cfg_if.data <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // one-bit registers get random upper bits, which must be dropped
  task automatic apply_settings(bit s16, bit d16, bit sst, bit dst,
                                bit [RateW-1:0] srate, bit [RateW-1:0] drate);
    cfg_write(CFG_SRC_SIXTEEN_BIT, {17'($urandom), s16});
    cfg_write(CFG_DST_SIXTEEN_BIT, {17'($urandom), d16});
    cfg_write(CFG_SRC_STEREO, {17'($urandom), sst});
    cfg_write(CFG_DST_STEREO, {17'($urandom), dst});
    cfg_write(CFG_SRC_RATE, srate);
    cfg_write(CFG_DST_RATE, drate);
    cfg_write(CfgSpareIdx, 18'($urandom));
    cfg_if.valid <= 1'b0;
    settings_done++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.results_seen != frames_sent) @(posedge clk_i);
  endtask

  initial begin
    #3_000_000;
    $display("timeout with %0d frames still awaiting a result", frames_sent - sb.results_seen);
    $display("tb_pcm_format_rate_convert: done, errors");
    $finish;
  end

  initial begin
    bit quiet;
    bit [RateW-1:0] srate;
    bit [RateW-1:0] drate;
    sb = new;
    sb.reset_state();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    no_idle = 1'b0;
    hold_req = 0;
    frames_sent = 0;
    settings_done = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 16-bit mono passthrough
    send_frame(make_frame(16'h0000, 16'h1234, 1'b1), 1'b0);
    send_frame(make_frame(16'h7FFF, 16'hFFFF, 1'b0), 1'b0);
    send_frame(make_frame(16'h8000, 16'h0000, 1'b0), 1'b0);
    send_frame(make_frame(16'hFFFF, 16'h8000, 1'b0), 1'b0);
    wait_drained();

    // 16 to 8 bit, stereo: truncation toward zero around small negatives
    apply_settings(1'b1, 1'b0, 1'b1, 1'b1, 18'd48000, 18'd44100);
    send_frame(make_frame(16'h7FFF, 16'h8000, 1'b1), 1'b0);
    send_frame(make_frame(16'hFF01, 16'h00FF, 1'b0), 1'b0);
    send_frame(make_frame(16'hFF00, 16'h0100, 1'b0), 1'b0);
    send_frame(make_frame(16'h8001, 16'h7F00, 1'b0), 1'b0);
    send_frame(make_frame(16'hFFFF, 16'h0000, 1'b0), 1'b0);
    wait_drained();

    // 8 to 16 bit, mono source into stereo destination
    apply_settings(1'b0, 1'b1, 1'b0, 1'b1, 18'd0, 18'd192000);
    send_frame(make_frame(16'h0000, 16'hFFFF, 1'b1), 1'b0);
    send_frame(make_frame(16'h00FF, 16'h1111, 1'b0), 1'b0);
    send_frame(make_frame(16'hAB80, 16'h2222, 1'b0), 1'b0);
    send_frame(make_frame(16'h127F, 16'h3333, 1'b0), 1'b0);
    wait_drained();

    // 8-bit passthrough, stereo source into mono destination
    apply_settings(1'b0, 1'b0, 1'b1, 1'b0, 18'h3FFFF, 18'd1);
    send_frame(make_frame(16'hFF00, 16'h00FF, 1'b1), 1'b0);
    send_frame(make_frame(16'h0080, 16'h0000, 1'b0), 1'b0);
    send_frame(make_frame(16'h55AA, 16'hAA55, 1'b0), 1'b0);
    send_frame(make_frame(16'hFFFF, 16'hFFFF, 1'b0), 1'b0);
    wait_drained();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: begin srate = 18'd0;      drate = 18'h3FFFF; end
        1: begin srate = 18'h3FFFF;  drate = 18'd1;     end
        2: begin srate = 18'd1;      drate = 18'd192000; end
        3: begin srate = 18'd192000; drate = 18'd0;     end
        default: begin srate = pick_rate(); drate = pick_rate(); end
      endcase
      if (phase < 4)
        apply_settings(phase[0], phase[1], 1'($urandom), 1'($urandom), srate, drate);
      else
        apply_settings(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), srate, drate);
      quiet = (phase % 5 == 4);
      no_idle <= quiet;
      if (phase == 6) hold_req <= hold_req + 1;
      for (int k = 0; k < PhaseFrames; k++)
        send_frame(random_frame(k == 0), quiet || (phase == 6 && k < 40));
      wait_drained();
    end

    repeat (EndWait) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report("frames left without a result", sb.expected_q.size(), 0);
    $display("%0d frames checked against %0d results over %0d register settings",
             sb.frames_noted, sb.results_seen, settings_done + 1);
    $display("all depth and channel layouts, rate extremes and a %0d-cycle output hold-off",
             LongHold);
    if (sb.errors == 0) begin
      $display("tb_pcm_format_rate_convert: done, clean");
    end else begin
      $display("tb_pcm_format_rate_convert: done, errors");
    end
    $finish;
  end

endmodule
